// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the S-record encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define SRHE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define SRHE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/srhe_pkg.sv -----
// Shared constants, types and helpers of the S-record encoder.
package srhe_pkg;

  // Largest number of data bytes one record can hold.
  localparam int unsigned MaxRecordBytes = 32;

  // Register reset values.
  localparam logic [5:0] BytesPerRecordReset = 6'd16;
  localparam logic [1:0] AddressFormatReset  = 2'd1;

  // Register indexes on the configuration port.
  localparam logic RegBytesPerRecord = 1'b0;
  localparam logic RegAddressFormat  = 1'b1;

  // Request codes of an input transaction.
  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqData  = 2'd1;
  localparam logic [1:0] ReqEnd   = 2'd2;

  // Character counts of a result transaction.
  localparam logic [1:0] CountPair   = 2'd2;
  localparam logic [1:0] CountSingle = 2'd1;

  // ASCII characters.
  localparam logic [7:0] CharS   = 8'h53;
  localparam logic [7:0] CharNl  = 8'h0A;
  localparam logic [7:0] CharNul = 8'h00;

  // One record to be written out by the record generator.
  typedef struct packed {
    logic [3:0] rec_type;    // digit after the 'S'
    logic [2:0] addr_bytes;  // number of address bytes
    logic [31:0] addr;       // record address
    logic [5:0] len;         // data bytes taken from the buffer
    logic [7:0] data_sum;    // sum of the data bytes, modulo 256
    logic last;              // record closes the input transaction
  } gen_cmd_t;

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

endpackage

// ----- hdl/srhe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module srhe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/srhe_gen.sv -----
// Record generator: turns one record command into hex character pairs.
`include "assert_macros.svh"

module srhe_gen #(
  parameter int unsigned MAX_RECORD_BYTES = srhe_pkg::MaxRecordBytes,
  localparam int unsigned IdxW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  srhe_pkg::gen_cmd_t cmd_i,
  output logic               busy_o,
  output logic [IdxW-1:0]    ram_raddr_o,
  input  logic [7:0]         ram_rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         char_first_o,
  output logic [7:0]         char_second_o,
  output logic [1:0]         char_count_o,
  output logic               last_o
);

  import srhe_pkg::*;

  typedef enum logic [2:0] {
    G_IDLE,
    G_HEAD,
    G_COUNT,
    G_ADDR,
    G_DATA,
    G_CSUM,
    G_NL
  } phase_e;

  phase_e           phase_q, phase_d;
  gen_cmd_t         cmd_q, cmd_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       csum_q, csum_d;
  logic [31:0]      ashift_q, ashift_d;
  logic [1:0]       acnt_q, acnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       second_q, second_d;
  logic [1:0]       ccount_q, ccount_d;
  logic             last_q, last_d;
  logic             adv;
  logic [7:0]       count_c;
  logic [7:0]       abyte;

  // The output register can take a new pair when empty or being drained.
  assign adv     = !out_valid_q || out_ready_i;
  assign count_c = 8'(cmd_i.addr_bytes) + 8'(cmd_i.len) + 8'd1;
  assign abyte   = ashift_q[31:24];

  // Sequencing of one record and formation of each pair.
  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    csum_d      = csum_q;
    ashift_d    = ashift_q;
    acnt_d      = acnt_q;
    idx_d       = idx_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    first_d     = first_q;
    second_d    = second_q;
    ccount_d    = ccount_q;
    last_d      = last_q;
    case (phase_q)
      G_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          cnt_d   = count_c;
          csum_d  = count_c + cmd_i.data_sum;
          idx_d   = '0;
          phase_d = G_HEAD;
          case (cmd_i.addr_bytes)
            3'd2:    ashift_d = {cmd_i.addr[15:0], 16'h0000};
            3'd3:    ashift_d = {cmd_i.addr[23:0], 8'h00};
            default: ashift_d = cmd_i.addr;
          endcase
        end
      end
      G_HEAD: begin
        if (adv) begin
          out_valid_d = 1'b1;
          first_d     = CharS;
          second_d    = hex_char(cmd_q.rec_type);
          ccount_d    = CountPair;
          last_d      = 1'b0;
          phase_d     = G_COUNT;
        end
      end
      G_COUNT: begin
        if (adv) begin
          out_valid_d = 1'b1;
          first_d     = hex_char(cnt_q[7:4]);
          second_d    = hex_char(cnt_q[3:0]);
          ccount_d    = CountPair;
          last_d      = 1'b0;
          acnt_d      = 2'(cmd_q.addr_bytes - 3'd1);
          phase_d     = G_ADDR;
        end
      end
      G_ADDR: begin
        if (adv) begin
          out_valid_d = 1'b1;
          first_d     = hex_char(abyte[7:4]);
          second_d    = hex_char(abyte[3:0]);
          ccount_d    = CountPair;
          last_d      = 1'b0;
          csum_d      = csum_q + abyte;
          ashift_d    = {ashift_q[23:0], 8'h00};
          if (acnt_q == 2'd0) begin
            idx_d   = '0;
            phase_d = (cmd_q.len != 6'd0) ? G_DATA : G_CSUM;
          end else begin
            acnt_d = acnt_q - 2'd1;
          end
        end
      end
      G_DATA: begin
        // The RAM is addressed with the next index, so its data matches idx_q.
        if (adv) begin
          out_valid_d = 1'b1;
          first_d     = hex_char(ram_rdata_i[7:4]);
          second_d    = hex_char(ram_rdata_i[3:0]);
          ccount_d    = CountPair;
          last_d      = 1'b0;
          if (6'(idx_q) == cmd_q.len - 6'd1) begin
            phase_d = G_CSUM;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      G_CSUM: begin
        if (adv) begin
          out_valid_d = 1'b1;
          first_d     = hex_char(~csum_q[7:4]);
          second_d    = hex_char(~csum_q[3:0]);
          ccount_d    = CountPair;
          last_d      = 1'b0;
          phase_d     = G_NL;
        end
      end
      G_NL: begin
        if (adv) begin
          out_valid_d = 1'b1;
          first_d     = CharNl;
          second_d    = CharNul;
          ccount_d    = CountSingle;
          last_d      = cmd_q.last;
          phase_d     = G_IDLE;
        end
      end
      default: begin
        phase_d = G_IDLE;
      end
    endcase
  end

  // Sequencer state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= G_IDLE;
      out_valid_q <= 1'b0;
      first_q     <= '0;
      second_q    <= '0;
      ccount_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      first_q     <= first_d;
      second_q    <= second_d;
      ccount_q    <= ccount_d;
      last_q      <= last_d;
    end
  end

  // Record context.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    cnt_q    <= cnt_d;
    csum_q   <= csum_d;
    ashift_q <= ashift_d;
    acnt_q   <= acnt_d;
    idx_q    <= idx_d;
  end

  assign busy_o        = (phase_q != G_IDLE);
  assign ram_raddr_o   = idx_d;
  assign out_valid_o   = out_valid_q;
  assign char_first_o  = first_q;
  assign char_second_o = second_q;
  assign char_count_o  = ccount_q;
  assign last_o        = last_q;

  `SRHE_ASSERT_IMP(a_cmd_when_idle, cmd_valid_i, phase_q == G_IDLE, "record command while busy")
  `SRHE_ASSERT_IMP(a_last_on_newline, out_valid_o && last_o, char_count_o == CountSingle,
                   "last flag away from the newline")
  `SRHE_ASSERT_NXT(a_stall_holds, out_valid_o && !out_ready_i, $stable(char_first_o),
                   "stalled pair changed")

endmodule

// ----- hdl/srhe_ctrl.sv -----
// Request controller: buffers data bytes and issues header, data and end records.
`include "assert_macros.svh"

module srhe_ctrl #(
  parameter int unsigned MAX_RECORD_BYTES = srhe_pkg::MaxRecordBytes,
  localparam int unsigned IdxW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1,
  localparam int unsigned CntW = $clog2(MAX_RECORD_BYTES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        address_i,
  input  logic [7:0]         data_byte_i,
  input  logic [5:0]         bytes_per_record_i,
  input  logic [1:0]         address_format_i,
  input  logic               gen_busy_i,
  output logic               cmd_valid_o,
  output srhe_pkg::gen_cmd_t cmd_o,
  output logic               ram_we_o,
  output logic [IdxW-1:0]    ram_waddr_o,
  output logic [7:0]         ram_wdata_o
);

  import srhe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_FLUSH,
    S_WAIT
  } state_e;

  localparam logic [5:0] MaxLen = 6'(MAX_RECORD_BYTES);

  state_e          state_q, state_d;
  logic [1:0]      req_q, req_d;
  logic [31:0]     addr_q, addr_d;
  logic [7:0]      byte_q, byte_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [31:0]     start_q, start_d;
  logic [7:0]      sum_q, sum_d;

  logic [1:0]      fmt;
  logic [31:0]     mask;
  logic [5:0]      limit;
  logic [31:0]     addr_m;
  logic [31:0]     expect_addr;
  logic            need_flush;
  logic            store;
  gen_cmd_t        flush_cmd, term_cmd, hdr_cmd;

  // Effective format, address mask and record length.
  always_comb begin
    fmt = (address_format_i == 2'd0) ? 2'd1 : address_format_i;
    case (fmt)
      2'd1:    mask = 32'h0000_FFFF;
      2'd2:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    if (bytes_per_record_i == 6'd0) begin
      limit = 6'd1;
    end else if (bytes_per_record_i > MaxLen) begin
      limit = MaxLen;
    end else begin
      limit = bytes_per_record_i;
    end
  end

  // Contiguity and length test for a new data byte.
  assign addr_m      = addr_q & mask;
  assign expect_addr = (start_q + 32'(fill_q)) & mask;
  assign need_flush  = (fill_q != '0) &&
                       ((addr_m != expect_addr) || (6'(fill_q) >= limit));

  // The three record kinds.
  always_comb begin
    flush_cmd.rec_type   = 4'(fmt);
    flush_cmd.addr_bytes = 3'(fmt) + 3'd1;
    flush_cmd.addr       = start_q & mask;
    flush_cmd.len        = 6'(fill_q);
    flush_cmd.data_sum   = sum_q;
    flush_cmd.last       = (req_q == ReqData);

    term_cmd.rec_type    = 4'd10 - 4'(fmt);
    term_cmd.addr_bytes  = 3'(fmt) + 3'd1;
    term_cmd.addr        = '0;
    term_cmd.len         = '0;
    term_cmd.data_sum    = '0;
    term_cmd.last        = 1'b1;

    hdr_cmd.rec_type     = 4'd0;
    hdr_cmd.addr_bytes   = 3'd2;
    hdr_cmd.addr         = '0;
    hdr_cmd.len          = '0;
    hdr_cmd.data_sum     = '0;
    hdr_cmd.last         = 1'b1;
  end

  // Request handling.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    addr_d      = addr_q;
    byte_d      = byte_q;
    fill_d      = fill_q;
    start_d     = start_q;
    sum_d       = sum_q;
    cmd_valid_o = 1'b0;
    cmd_o       = hdr_cmd;
    store       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          addr_d  = address_i;
          byte_d  = data_byte_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (req_q)
          ReqStart: begin
            fill_d      = '0;
            sum_d       = '0;
            cmd_valid_o = 1'b1;
            cmd_o       = hdr_cmd;
            state_d     = S_WAIT;
          end
          ReqData: begin
            if (need_flush) begin
              cmd_valid_o = 1'b1;
              cmd_o       = flush_cmd;
              fill_d      = '0;
              sum_d       = '0;
              state_d     = S_FLUSH;
            end else begin
              store   = 1'b1;
              state_d = S_IDLE;
            end
          end
          ReqEnd: begin
            cmd_valid_o = 1'b1;
            if (fill_q != '0) begin
              cmd_o   = flush_cmd;
              fill_d  = '0;
              sum_d   = '0;
              state_d = S_FLUSH;
            end else begin
              cmd_o   = term_cmd;
              state_d = S_WAIT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FLUSH: begin
        // Once the pending record is out, store the byte or close the stream.
        if (!gen_busy_i) begin
          if (req_q == ReqData) begin
            store   = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_valid_o = 1'b1;
            cmd_o       = term_cmd;
            state_d     = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (!gen_busy_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Append the byte to the buffer.
    if (store) begin
      fill_d = fill_q + 1'b1;
      if (fill_q == '0) begin
        start_d = addr_m;
        sum_d   = byte_q;
      end else begin
        sum_d = sum_q + byte_q;
      end
    end
  end

  // Controller state and buffer bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      start_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      start_q <= start_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    addr_q <= addr_d;
    byte_q <= byte_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign ram_we_o    = store;
  assign ram_waddr_o = fill_q[IdxW-1:0];
  assign ram_wdata_o = byte_q;

  `SRHE_ASSERT_IMP(a_ready_gen_idle, in_ready_o, !gen_busy_i,
                   "input taken while a record is still being written")
  `SRHE_ASSERT_NXT(a_store_fills, ram_we_o, fill_q != '0, "stored byte not counted")
  `SRHE_ASSERT_IMP(a_fill_bound, ram_we_o, fill_q < CntW'(MAX_RECORD_BYTES),
                   "buffer overflow")

endmodule

// ----- hdl/srecord_hex_encoder.sv -----
// Motorola S-record encoder top level: configuration registers and datapath.
// A data transaction that only buffers its byte is accepted, then evaluated.
// A transaction that emits a record of n pairs gets one pair a cycle from the record
// generator while the output side keeps up; an end with pending data writes two
// records back to back.
// Reset clears control state; the record buffer RAM is not cleared, only filled entries are read.
module srecord_hex_encoder #(
  parameter int unsigned MAX_RECORD_BYTES = srhe_pkg::MaxRecordBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  char_first_o,
  output logic [7:0]  char_second_o,
  output logic [1:0]  char_count_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import srhe_pkg::*;

  localparam int unsigned IdxW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

  logic [5:0]      bpr_q, bpr_d;
  logic [1:0]      fmt_q, fmt_d;
  logic            cfg_we;
  logic            gen_busy;
  logic            cmd_valid;
  gen_cmd_t        cmd;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  // Configuration register writes on the access phase.
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    bpr_d = bpr_q;
    fmt_d = fmt_q;
    if (cfg_we) begin
      case (paddr[2])
        RegBytesPerRecord: bpr_d = pwdata[5:0];
        RegAddressFormat:  fmt_d = pwdata[1:0];
        default:           bpr_d = bpr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q <= BytesPerRecordReset;
      fmt_q <= AddressFormatReset;
    end else begin
      bpr_q <= bpr_d;
      fmt_q <= fmt_d;
    end
  end

  // Register read-back.
  assign prdata = (paddr[2] == RegAddressFormat) ? {30'h0, fmt_q} : {26'h0, bpr_q};
  assign pready = 1'b1;

  srhe_ctrl #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .address_i         (address_i),
    .data_byte_i       (data_byte_i),
    .bytes_per_record_i(bpr_q),
    .address_format_i  (fmt_q),
    .gen_busy_i        (gen_busy),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata)
  );

  srhe_ram #(
    .Width(8),
    .Depth(MAX_RECORD_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  srhe_gen #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .busy_o       (gen_busy),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_first_o (char_first_o),
    .char_second_o(char_second_o),
    .char_count_o (char_count_o),
    .last_o       (last_o)
  );

endmodule
